### hdl/sse_pkg.sv
`default_nettype none

package sse_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_FLAG  = 2'd1,
      CMD_RUN   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SAT   = 2'd1,
      ST_PIVOT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SRC_HOST = 2'd0,
      SRC_MUL  = 2'd1,
      SRC_ADD  = 2'd2,
      SRC_ZERO = 2'd3
   } src_type;

   typedef struct packed {
      logic       wr_en;
      src_type    wr_src;
      logic       mul_start;
      logic       mul_use_ax;
      logic       ax_latch;
      logic       piv_check;
      logic       sat_clear;
      logic       err_set;
      status_type err_code;
      logic       hold_load;
      logic       hold_ok;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic pivot_bad;
      logic sat;
   } dp_sts_type;

endpackage

`default_nettype wire

### hdl/silent_state_elimination.sv
`default_nettype none

// Write and set-flag requests are carried out on acceptance and give no response; a read
// passes through S_READ and S_LOAD before its response. A run uses the shift-add
// multiplier for each product and the restoring divider for each pivot.
// One request at a time.
// Synchronous active-high reset clears control, silent flags and status, and sets
// states_in_use to 16; matrix entries hold nothing defined until written.
module silent_state_elimination #(
   parameter int MAX_STATES  = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [4:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // row_index, column_index, entry_value, silent_flag
   input  wire logic [1:0]  req_tuser,  // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata   // read_value, status
);

   localparam int IW = $clog2(MAX_STATES);

   sse_pkg::dp_cmd_type dp_cmd;
   sse_pkg::dp_sts_type dp_sts;
   logic [IW-1:0]       row;
   logic [IW-1:0]       col;
   logic [31:0]         rsp_value;
   logic [1:0]          rsp_status;

   sse_controller #(
      .MAX_STATES(MAX_STATES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_cmd  (sse_pkg::cmd_type'(req_tuser)),
      .req_row  (req_tdata[3:0]),
      .req_col  (req_tdata[7:4]),
      .req_flag (req_tdata[40]),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .cmd      (dp_cmd),
      .row      (row),
      .col      (col),
      .sts      (dp_sts)
   );

   sse_datapath #(
      .MAX_STATES (MAX_STATES),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .row        (row),
      .col        (col),
      .entry_value(req_tdata[39:8]),
      .sts        (dp_sts),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {6'd0, rsp_status, rsp_value};

`ifndef SYNTHESIS
   a_mul_not_instant: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.mul_start |=> !dp_sts.mul_done)
      else $error("multiplier reported done right after start");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.rsp_load |=> rsp_tvalid)
      else $error("loaded response not presented");

   a_pivot_stops: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.piv_check && dp_sts.pivot_bad) |=> !req_tready && !dp_cmd.mul_start)
      else $error("run continued after bad pivot");
`endif

endmodule

`default_nettype wire

### hdl/sse_ram.sv
`default_nettype none

module sse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/sse_datapath.sv
`default_nettype none

module sse_datapath #(
   parameter int MAX_STATES  = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sse_pkg::dp_cmd_type           cmd,
   input  wire logic [$clog2(MAX_STATES)-1:0] row,
   input  wire logic [$clog2(MAX_STATES)-1:0] col,
   input  wire logic [31:0]                   entry_value,
   output sse_pkg::dp_sts_type                sts,
   output logic      [31:0]                   rsp_value,
   output logic      [1:0]                    rsp_status
);

   localparam int VW    = VALUE_WIDTH;
   localparam int F     = VW - 2;
   localparam int E     = 2 * F;
   localparam int DEPTH = MAX_STATES * MAX_STATES;
   localparam int AW    = $clog2(DEPTH);
   localparam int MCW   = $clog2(VW);
   localparam int DCW   = $clog2(E + 1);
   localparam int SH_UP = (VW > 32) ? VW - 32 : 0;
   localparam int SH_DN = (VW < 32) ? 32 - VW : 0;
   localparam logic [VW-1:0]   MAXV    = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0]   MINV    = {1'b1, {(VW-1){1'b0}}};
   localparam logic [VW+1:0]   NEG_LIM = (VW+2)'(1) << (VW - 1);
   localparam logic [VW+1:0]   POS_LIM = NEG_LIM - (VW+2)'(1);
   localparam logic signed [VW:0] ONE  = (VW+1)'(1) << F;

   logic [AW-1:0]     addr;
   logic [VW-1:0]     rd_data;
   logic [VW-1:0]     wr_data;
   logic signed [95:0] in_wide;
   logic signed [95:0] in_shift;
   logic signed [95:0] out_wide;
   logic signed [95:0] out_shift;

   // saturating add
   logic signed [VW:0] sum;
   logic               add_ovf;
   logic [VW-1:0]      add_res;

   // pivot
   logic signed [VW:0] diff;
   logic               pivot_bad;
   logic [VW-1:0]      pivot;
   logic               pivot_sat;

   // multiplier
   logic [2*VW-1:0] mcand_ff, mcand_in;
   logic [VW-1:0]   mplier_ff, mplier_in;
   logic [2*VW-1:0] acc_ff, acc_in, acc_nx;
   logic [MCW-1:0]  mcnt_ff, mcnt_in;
   logic            mbusy_ff, mbusy_in;
   logic            mneg_ff, mneg_in;
   logic            mdone_ff, mdone_in;
   logic [VW-1:0]   mul_q_ff, mul_q_in;
   logic [VW-1:0]   op_a, op_b, mag_a, mag_b;
   logic [VW+1:0]   prod_m;
   logic [VW+1:0]   prod_neg;
   logic [VW-1:0]   mul_res;
   logic            mul_ovf;

   // divider
   logic [VW-1:0]   dvd_ff, dvd_in;
   logic [VW-1:0]   rem_ff, rem_in;
   logic [E:0]      quo_ff, quo_in;
   logic [DCW-1:0]  dcnt_ff, dcnt_in;
   logic            dbusy_ff, dbusy_in;
   logic            ddone_ff, ddone_in;
   logic [VW:0]     rem_sh;
   logic            qbit;
   logic [E:0]      quo_nx;
   logic            div_ovf;
   logic [VW-1:0]   factor_ff, factor_in;

   logic [VW-1:0]   ax_ff, ax_in;
   logic            sat_ff, sat_in;
   logic [1:0]      err_ff, err_in;
   logic [31:0]     hold_ff, hold_in;
   logic [31:0]     rsp_value_ff, rsp_value_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;

   assign addr = AW'(row) * AW'(MAX_STATES) + AW'(col);

   sse_ram #(
      .WIDTH(VW),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(addr),
      .wr_data(wr_data),
      .rd_addr(addr),
      .rd_data(rd_data)
   );

   always_comb begin
      in_wide   = {{64{entry_value[31]}}, entry_value};
      in_shift  = (in_wide <<< SH_UP) >>> SH_DN;
      out_wide  = {{(96-VW){rd_data[VW-1]}}, rd_data};
      out_shift = (out_wide >>> SH_UP) <<< SH_DN;

      sum     = $signed({rd_data[VW-1], rd_data}) + $signed({mul_q_ff[VW-1], mul_q_ff});
      add_ovf = sum[VW] != sum[VW-1];
      add_res = add_ovf ? (sum[VW] ? MINV : MAXV) : sum[VW-1:0];

      diff      = ONE - $signed({rd_data[VW-1], rd_data});
      pivot_bad = diff <= 0;
      pivot_sat = diff > $signed({1'b0, MAXV});
      pivot     = pivot_sat ? MAXV : diff[VW-1:0];

      case (cmd.wr_src)
         sse_pkg::SRC_HOST: wr_data = in_shift[VW-1:0];
         sse_pkg::SRC_MUL:  wr_data = mul_q_ff;
         sse_pkg::SRC_ADD:  wr_data = add_res;
         sse_pkg::SRC_ZERO: wr_data = '0;
         default:           wr_data = '0;
      endcase
   end

   // shift-add multiplier on magnitudes, floor rounding, saturation
   always_comb begin
      op_a      = rd_data;
      op_b      = cmd.mul_use_ax ? ax_ff : factor_ff;
      mag_a     = op_a[VW-1] ? VW'(-op_a) : op_a;
      mag_b     = op_b[VW-1] ? VW'(-op_b) : op_b;
      acc_nx    = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
      prod_m    = acc_nx[2*VW-1:F] + (VW+2)'(mneg_ff && (|acc_nx[F-1:0]));
      prod_neg  = (VW+2)'(-prod_m);
      if (mneg_ff) begin
         mul_ovf = prod_m > NEG_LIM;
         mul_res = mul_ovf ? MINV : prod_neg[VW-1:0];
      end else begin
         mul_ovf = prod_m > POS_LIM;
         mul_res = mul_ovf ? MAXV : prod_m[VW-1:0];
      end

      mcand_in  = mcand_ff << 1;
      mplier_in = mplier_ff >> 1;
      acc_in    = acc_nx;
      mcnt_in   = mcnt_ff - MCW'(1);
      mbusy_in  = mbusy_ff;
      mneg_in   = mneg_ff;
      mdone_in  = 1'b0;
      mul_q_in  = mul_q_ff;
      if (cmd.mul_start) begin
         mcand_in  = {{VW{1'b0}}, mag_b};
         mplier_in = mag_a;
         acc_in    = '0;
         mcnt_in   = MCW'(VW - 1);
         mbusy_in  = 1'b1;
         mneg_in   = op_a[VW-1] ^ op_b[VW-1];
      end else if (mbusy_ff && mcnt_ff == '0) begin
         mbusy_in = 1'b0;
         mdone_in = 1'b1;
         mul_q_in = mul_res;
      end
   end

   // restoring divider for floor(1.0 / pivot)
   always_comb begin
      rem_sh    = {rem_ff, (dcnt_ff == DCW'(E))};
      qbit      = rem_sh >= {1'b0, dvd_ff};
      rem_in    = qbit ? VW'(rem_sh - {1'b0, dvd_ff}) : rem_sh[VW-1:0];
      quo_nx    = {quo_ff[E-1:0], qbit};
      div_ovf   = quo_nx > (E+1)'(MAXV);
      quo_in    = quo_nx;
      dvd_in    = dvd_ff;
      dcnt_in   = dcnt_ff - DCW'(1);
      dbusy_in  = dbusy_ff;
      ddone_in  = 1'b0;
      factor_in = factor_ff;
      if (cmd.piv_check && !pivot_bad) begin
         dvd_in   = pivot;
         rem_in   = '0;
         quo_in   = '0;
         dcnt_in  = DCW'(E);
         dbusy_in = 1'b1;
      end else if (dbusy_ff && dcnt_ff == '0) begin
         dbusy_in  = 1'b0;
         ddone_in  = 1'b1;
         factor_in = div_ovf ? MAXV : quo_nx[VW-1:0];
      end
   end

   always_comb begin
      ax_in = cmd.ax_latch ? mul_q_ff : ax_ff;
      sat_in = sat_ff;
      if (cmd.sat_clear) begin
         sat_in = 1'b0;
      end else if ((mbusy_ff && !cmd.mul_start && mcnt_ff == '0 && mul_ovf)
            || (dbusy_ff && dcnt_ff == '0 && div_ovf)
            || (cmd.piv_check && !pivot_bad && pivot_sat)
            || (cmd.wr_en && cmd.wr_src == sse_pkg::SRC_ADD && add_ovf)) begin
         sat_in = 1'b1;
      end
      err_in  = cmd.err_set ? cmd.err_code : err_ff;
      hold_in = cmd.hold_load ? (cmd.hold_ok ? out_shift[31:0] : '0) : hold_ff;
      rsp_value_in  = cmd.rsp_load ? hold_ff : rsp_value_ff;
      rsp_status_in = cmd.rsp_load ? err_ff : rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mdone_ff <= 1'b0;
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
         sat_ff   <= 1'b0;
         err_ff   <= sse_pkg::ST_OK;
      end else begin
         mbusy_ff <= mbusy_in;
         mdone_ff <= mdone_in;
         dbusy_ff <= dbusy_in;
         ddone_ff <= ddone_in;
         sat_ff   <= sat_in;
         err_ff   <= err_in;
      end
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      acc_ff        <= acc_in;
      mcnt_ff       <= mcnt_in;
      mneg_ff       <= mneg_in;
      mul_q_ff      <= mul_q_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dcnt_ff       <= dcnt_in;
      factor_ff     <= factor_in;
      ax_ff         <= ax_in;
      hold_ff       <= hold_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      sts.mul_done  = mdone_ff;
      sts.div_done  = ddone_ff;
      sts.pivot_bad = pivot_bad;
      sts.sat       = sat_ff;
   end

   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

### hdl/sse_controller.sv
`default_nettype none

module sse_controller #(
   parameter int MAX_STATES = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [4:0]                    csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire sse_pkg::cmd_type              req_cmd,
   input  wire logic [3:0]                    req_row,
   input  wire logic [3:0]                    req_col,
   input  wire logic                          req_flag,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output sse_pkg::dp_cmd_type                cmd,
   output logic      [$clog2(MAX_STATES)-1:0] row,
   output logic      [$clog2(MAX_STATES)-1:0] col,
   input  wire sse_pkg::dp_sts_type           sts
);

   localparam int IW = $clog2(MAX_STATES);
   localparam int CW = $clog2(MAX_STATES + 1);

   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_READ     = 15'b000000000000010,
      S_PIV_FIND = 15'b000000000000100,
      S_PIV_WAIT = 15'b000000000001000,
      S_DIV      = 15'b000000000010000,
      S_X_FIND   = 15'b000000000100000,
      S_AX_WAIT  = 15'b000000001000000,
      S_AX_MUL   = 15'b000000010000000,
      S_B_FIND   = 15'b000000100000000,
      S_BA_WAIT  = 15'b000001000000000,
      S_BA_MUL   = 15'b000010000000000,
      S_BX_WAIT  = 15'b000100000000000,
      S_CLR_ROW  = 15'b001000000000000,
      S_CLR_COL  = 15'b010000000000000,
      S_LOAD     = 15'b100000000000000
   } state_type;

   state_type             state_ff, state_in;
   logic [4:0]            states_ff, states_in;
   logic [MAX_STATES-1:0] mask_ff, mask_in;
   logic [CW-1:0]         a_ff, a_in, x_ff, x_in, b_ff, b_in;
   logic                  ok_ff, ok_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]         n;
   logic                  accept;
   logic                  req_ok;
   logic                  silent_a, silent_x, silent_b;

   always_comb begin
      if (int'(states_ff) > MAX_STATES) begin
         n = CW'(MAX_STATES);
      end else begin
         n = CW'(states_ff);
      end
      req_ready = state_ff == S_IDLE;
      accept    = req_valid && req_ready;
      req_ok    = (int'(req_row) < MAX_STATES) && (int'(req_col) < MAX_STATES);
      silent_a  = (a_ff < n) && mask_ff[a_ff[IW-1:0]];
      silent_x  = (x_ff < n) && mask_ff[x_ff[IW-1:0]];
      silent_b  = (b_ff < n) && mask_ff[b_ff[IW-1:0]];
   end

   always_comb begin
      state_in     = state_ff;
      states_in    = csr_we ? csr_wdata : states_ff;
      mask_in      = mask_ff;
      a_in         = a_ff;
      x_in         = x_ff;
      b_in         = b_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      row          = a_ff[IW-1:0];
      col          = x_ff[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            row = IW'(req_row);
            col = IW'(req_col);
            if (accept) begin
               case (req_cmd)
                  sse_pkg::CMD_WRITE: begin
                     cmd.wr_en  = req_ok;
                     cmd.wr_src = sse_pkg::SRC_HOST;
                  end
                  sse_pkg::CMD_FLAG: begin
                     if (int'(req_row) < MAX_STATES) begin
                        mask_in[IW'(req_row)] = req_flag;
                     end
                  end
                  sse_pkg::CMD_RUN: begin
                     cmd.sat_clear = 1'b1;
                     a_in          = '0;
                     state_in      = S_PIV_FIND;
                  end
                  sse_pkg::CMD_READ: begin
                     ok_in    = req_ok;
                     state_in = S_READ;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.hold_load = 1'b1;
            cmd.hold_ok   = ok_ff;
            state_in      = S_LOAD;
         end
         S_PIV_FIND: begin
            col = a_ff[IW-1:0];
            if (a_ff >= n) begin
               b_in     = '0;
               state_in = S_CLR_ROW;
            end else if (silent_a) begin
               state_in = S_PIV_WAIT;
            end else begin
               a_in = a_ff + CW'(1);
            end
         end
         S_PIV_WAIT: begin
            cmd.piv_check = 1'b1;
            if (sts.pivot_bad) begin
               cmd.err_set   = 1'b1;
               cmd.err_code  = sse_pkg::ST_PIVOT;
               cmd.hold_load = 1'b1;
               state_in      = S_LOAD;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               x_in     = '0;
               state_in = S_X_FIND;
            end
         end
         S_X_FIND: begin
            if (x_ff >= n) begin
               a_in     = a_ff + CW'(1);
               state_in = S_PIV_FIND;
            end else if (!silent_x || x_ff > a_ff) begin
               state_in = S_AX_WAIT;
            end else begin
               x_in = x_ff + CW'(1);
            end
         end
         S_AX_WAIT: begin
            cmd.mul_start = 1'b1;
            state_in      = S_AX_MUL;
         end
         S_AX_MUL: begin
            if (sts.mul_done) begin
               cmd.wr_en    = 1'b1;
               cmd.wr_src   = sse_pkg::SRC_MUL;
               cmd.ax_latch = 1'b1;
               b_in         = '0;
               state_in     = S_B_FIND;
            end
         end
         S_B_FIND: begin
            row = b_ff[IW-1:0];
            col = a_ff[IW-1:0];
            if (b_ff >= n) begin
               x_in     = x_ff + CW'(1);
               state_in = S_X_FIND;
            end else if (silent_b && b_ff != a_ff) begin
               state_in = S_BA_WAIT;
            end else begin
               b_in = b_ff + CW'(1);
            end
         end
         S_BA_WAIT: begin
            cmd.mul_start  = 1'b1;
            cmd.mul_use_ax = 1'b1;
            state_in       = S_BA_MUL;
         end
         S_BA_MUL: begin
            row = b_ff[IW-1:0];
            if (sts.mul_done) begin
               state_in = S_BX_WAIT;
            end
         end
         S_BX_WAIT: begin
            row        = b_ff[IW-1:0];
            cmd.wr_en  = 1'b1;
            cmd.wr_src = sse_pkg::SRC_ADD;
            b_in       = b_ff + CW'(1);
            state_in   = S_B_FIND;
         end
         S_CLR_ROW: begin
            if (b_ff >= n) begin
               cmd.err_set   = 1'b1;
               cmd.err_code  = sts.sat ? sse_pkg::ST_SAT : sse_pkg::ST_OK;
               cmd.hold_load = 1'b1;
               state_in      = S_LOAD;
            end else if (silent_b) begin
               x_in     = '0;
               state_in = S_CLR_COL;
            end else begin
               b_in = b_ff + CW'(1);
            end
         end
         S_CLR_COL: begin
            row = b_ff[IW-1:0];
            if (x_ff >= n) begin
               b_in     = b_ff + CW'(1);
               state_in = S_CLR_ROW;
            end else begin
               cmd.wr_en  = silent_x;
               cmd.wr_src = sse_pkg::SRC_ZERO;
               x_in       = x_ff + CW'(1);
            end
         end
         S_LOAD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         states_ff    <= 5'd16;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         states_ff    <= states_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff  <= a_in;
      x_ff  <= x_in;
      b_ff  <= b_in;
      ok_ff <= ok_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### verif/tb.sv
module tb;

   typedef struct packed {
      logic [31:0]         value;
      sse_pkg::status_type status;
   } rsp_type;

   typedef struct {
      sse_pkg::cmd_type    cmd;
      logic [3:0]          row;
      logic [3:0]          col;
      logic [31:0]         value;
      logic                flag;
      bit                  typed;
      logic [31:0]         exp_value;
      sse_pkg::status_type exp_status;
   } step_type;

   localparam longint VMAX = 64'sh7fff_ffff;
   localparam longint VMIN = -64'sh8000_0000;
   localparam longint ONE  = 64'sh4000_0000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [4:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   longint              matrix [256];
   logic [15:0]         silent_mask;
   sse_pkg::status_type run_status;
   int                  states_used;
   bit                  sat_seen;
   rsp_type             pending_rsp [$];
   bit                  no_idle = 1'b0;
   int                  errors = 0;
   step_type            steps [$];

   silent_state_elimination DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #80_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic longint clamp(longint v);
      if (v > VMAX) begin
         sat_seen = 1'b1;
         return VMAX;
      end
      if (v < VMIN) begin
         sat_seen = 1'b1;
         return VMIN;
      end
      return v;
   endfunction

   function automatic longint mul_q(longint a, longint b);
      longint p;
      p = a * b;
      return clamp(p >>> 30);
   endfunction

   function automatic longint recip_q(longint pivot);
      longint unsigned q;
      q = (64'd1 << 60) / longint'(pivot);
      if (q > 64'h7fff_ffff) begin
         sat_seen = 1'b1;
         return VMAX;
      end
      return longint'(q);
   endfunction

   function automatic sse_pkg::status_type eliminate_silent();
      int order [16];
      int n, nsil, nall, a, b, x;
      longint pivot, factor;
      n = states_used > 16 ? 16 : states_used;
      nall = 0;
      sat_seen = 1'b0;
      for (int s = 0; s < n; s++)
         if (silent_mask[s]) begin
            order[nall] = s;
            nall++;
         end
      nsil = nall;
      for (int s = 0; s < n; s++)
         if (!silent_mask[s]) begin
            order[nall] = s;
            nall++;
         end
      for (int i = 0; i < nsil; i++) begin
         a = order[i];
         pivot = clamp(ONE - matrix[a*16+a]);
         if (pivot <= 0) return sse_pkg::ST_PIVOT;
         factor = recip_q(pivot);
         for (int j = i + 1; j < nall; j++) begin
            x = order[j];
            matrix[a*16+x] = mul_q(matrix[a*16+x], factor);
            for (int k = 0; k < nsil; k++) begin
               b = order[k];
               if (b != a)
                  matrix[b*16+x] = clamp(matrix[b*16+x] +
                                         mul_q(matrix[b*16+a], matrix[a*16+x]));
            end
         end
      end
      for (int i = 0; i < nsil; i++)
         for (int j = 0; j < nsil; j++)
            matrix[order[i]*16+order[j]] = 0;
      return sat_seen ? sse_pkg::ST_SAT : sse_pkg::ST_OK;
   endfunction

   // returns 1 when the request produces a response
   function automatic bit predict(sse_pkg::cmd_type cmd, logic [3:0] r, logic [3:0] c,
                                  logic [31:0] v, logic f, output rsp_type exp);
      exp = '0;
      case (cmd)
         sse_pkg::CMD_WRITE: matrix[r*16+c] = longint'(signed'(v));
         sse_pkg::CMD_FLAG: silent_mask[r] = f;
         sse_pkg::CMD_RUN: begin
            run_status = eliminate_silent();
            exp.status = run_status;
            return 1'b1;
         end
         default: begin
            exp.value = matrix[r*16+c][31:0];
            exp.status = run_status;
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   task automatic send(sse_pkg::cmd_type cmd, logic [3:0] r, logic [3:0] c,
                       logic [31:0] v, logic f, bit typed = 0, logic [31:0] ev = '0,
                       sse_pkg::status_type es = sse_pkg::ST_OK);
      rsp_type exp;
      while (!no_idle && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'b0, f, v, c, r};
      do @(posedge clock); while (!req_tready);
      if (predict(cmd, r, c, v, f, exp)) begin
         if (typed) begin
            exp.value = ev;
            exp.status = es;
         end
         pending_rsp = {pending_rsp, exp};
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_states(logic [4:0] n);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= n;
      @(posedge clock);
      csr_we <= 1'b0;
      states_used = int'(n);
   endtask

   task automatic add_step(sse_pkg::cmd_type cmd, logic [3:0] r, logic [3:0] c,
                           logic [31:0] v, logic f, bit typed = 0, logic [31:0] ev = '0,
                           sse_pkg::status_type es = sse_pkg::ST_OK);
      step_type s;
      s.cmd = cmd; s.row = r; s.col = c; s.value = v; s.flag = f;
      s.typed = typed; s.exp_value = ev; s.exp_status = es;
      steps = {steps, s};
   endtask

   always @(posedge clock)
      rsp_tready <= no_idle || $urandom_range(99) >= 12;

   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response expected none actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            exp = pending_rsp.pop_front();
            if (rsp_tdata[31:0] !== exp.value) begin
               $display("%0t: read_value expected %h actual %h", $time, exp.value,
                        rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[33:32] !== exp.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp.status,
                        rsp_tdata[33:32]);
               errors++;
            end
         end
      end
   end

   initial begin
      int n, k;
      logic [31:0] v;
      for (int i = 0; i < 256; i++) matrix[i] = 0;
      silent_mask = '0;
      run_status = sse_pkg::ST_OK;
      states_used = 16;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the entries of states 0 to 5 before the first run
      no_idle = 1'b1;
      for (int i = 0; i < 36; i++)
         send(sse_pkg::CMD_WRITE, 4'(i / 6), 4'(i % 6), $urandom_range(32'h0800_0000),
              1'b0);
      no_idle = 1'b0;
      send(sse_pkg::CMD_RUN, 4'd0, 4'd0, 32'h0, 1'b0, 1, 32'h0, sse_pkg::ST_OK);
      set_states(5'd6);

      add_step(sse_pkg::CMD_READ, 4'd2, 4'd3, 32'h0, 1'b0);
      add_step(sse_pkg::CMD_WRITE, 4'd0, 4'd0, 32'h8000_0000, 1'b0);
      add_step(sse_pkg::CMD_READ, 4'd0, 4'd0, 32'h0, 1'b0, 1, 32'h8000_0000,
               sse_pkg::ST_OK);
      add_step(sse_pkg::CMD_WRITE, 4'd15, 4'd15, 32'h7fff_ffff, 1'b0);
      add_step(sse_pkg::CMD_READ, 4'd15, 4'd15, 32'h0, 1'b0, 1, 32'h7fff_ffff,
               sse_pkg::ST_OK);
      add_step(sse_pkg::CMD_WRITE, 4'd3, 4'd5, 32'h0, 1'b0);
      add_step(sse_pkg::CMD_READ, 4'd3, 4'd5, 32'h0, 1'b0, 1, 32'h0, sse_pkg::ST_OK);
      add_step(sse_pkg::CMD_RUN, 4'd0, 4'd0, 32'h0, 1'b0, 1, 32'h0, sse_pkg::ST_OK);
      add_step(sse_pkg::CMD_FLAG, 4'd15, 4'd0, 32'h0, 1'b1);
      add_step(sse_pkg::CMD_FLAG, 4'd15, 4'd0, 32'h0, 1'b0);
      add_step(sse_pkg::CMD_FLAG, 4'd0, 4'd0, 32'h0, 1'b1);
      add_step(sse_pkg::CMD_RUN, 4'd0, 4'd0, 32'h0, 1'b0);
      add_step(sse_pkg::CMD_READ, 4'd0, 4'd4, 32'h0, 1'b0);
      add_step(sse_pkg::CMD_READ, 4'd0, 4'd0, 32'h0, 1'b0, 1, 32'h0, sse_pkg::ST_SAT);
      add_step(sse_pkg::CMD_WRITE, 4'd0, 4'd0, 32'h4000_0000, 1'b0);
      add_step(sse_pkg::CMD_RUN, 4'd0, 4'd0, 32'h0, 1'b0, 1, 32'h0, sse_pkg::ST_PIVOT);
      add_step(sse_pkg::CMD_READ, 4'd0, 4'd0, 32'h0, 1'b0, 1, 32'h4000_0000,
               sse_pkg::ST_PIVOT);
      add_step(sse_pkg::CMD_WRITE, 4'd0, 4'd0, 32'h2000_0000, 1'b0);
      add_step(sse_pkg::CMD_FLAG, 4'd1, 4'd0, 32'h0, 1'b1);
      add_step(sse_pkg::CMD_RUN, 4'd0, 4'd0, 32'h0, 1'b0);
      add_step(sse_pkg::CMD_READ, 4'd1, 4'd4, 32'h0, 1'b0);
      foreach (steps[i])
         send(steps[i].cmd, steps[i].row, steps[i].col, steps[i].value, steps[i].flag,
              steps[i].typed, steps[i].exp_value, steps[i].exp_status);

      set_states(5'd0);
      send(sse_pkg::CMD_RUN, 4'd0, 4'd0, 32'h0, 1'b0, 1, 32'h0, sse_pkg::ST_OK);
      set_states(5'd1);
      send(sse_pkg::CMD_RUN, 4'd0, 4'd0, 32'h0, 1'b0);
      send(sse_pkg::CMD_FLAG, 4'd0, 4'd0, 32'h0, 1'b0);
      send(sse_pkg::CMD_FLAG, 4'd1, 4'd0, 32'h0, 1'b0);
      set_states(5'd31);
      send(sse_pkg::CMD_RUN, 4'd0, 4'd0, 32'h0, 1'b0, 1, 32'h0, sse_pkg::ST_OK);
      send(sse_pkg::CMD_FLAG, 4'd1, 4'd0, 32'h0, 1'b1);
      set_states(5'd2);
      send(sse_pkg::CMD_RUN, 4'd0, 4'd0, 32'h0, 1'b0);
      send(sse_pkg::CMD_READ, 4'd0, 4'd1, 32'h0, 1'b0);
      send(sse_pkg::CMD_READ, 4'd1, 4'd0, 32'h0, 1'b0);

      for (int phase = 0; phase < 5; phase++) begin
         n = $urandom_range(2, 6);
         set_states(5'(n));
         no_idle = (phase == 2);
         for (int i = 0; i < 6; i++)
            send(sse_pkg::CMD_FLAG, 4'(i), 4'd0, 32'h0, i < n && $urandom_range(1) != 0);
         for (int i = 0; i < 6; i++) begin
            k = $urandom_range(99);
            v = $urandom_range(7) == 0 ? $urandom : $urandom_range(32'h1000_0000);
            if (k < 55)
               send(sse_pkg::CMD_WRITE, 4'($urandom_range(n - 1)),
                    4'($urandom_range(n - 1)), v, 1'b0);
            else if (k < 65)
               send(sse_pkg::CMD_WRITE, 4'($urandom), 4'($urandom), $urandom,
                    1'($urandom));
            else if (k < 75)
               send(sse_pkg::CMD_FLAG, 4'($urandom), 4'($urandom), $urandom,
                    1'($urandom));
            else
               send(sse_pkg::CMD_READ, 4'($urandom_range(5)), 4'($urandom_range(5)),
                    $urandom, 1'($urandom));
            if (i == 3 && phase == 3) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (pending_rsp.size() != 0) @(posedge clock);
            end
         end
         send(sse_pkg::CMD_RUN, 4'($urandom), 4'($urandom), $urandom, 1'($urandom));
         for (int i = 0; i < 2; i++)
            send(sse_pkg::CMD_READ, 4'($urandom_range(n - 1)), 4'($urandom_range(n - 1)),
                 $urandom, 1'($urandom));
      end
      no_idle = 1'b0;

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
